FILE: sv/dmtr_pkg.sv
// Shared types, codes and constants of the DHCP message type responder.
`default_nettype none
package dmtr_pkg;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_COOKIE = 8'b0000_0010,
        PH_TYPE   = 8'b0000_0100,
        PH_LEN    = 8'b0000_1000,
        PH_SKIP   = 8'b0001_0000,
        PH_MTLEN  = 8'b0010_0000,
        PH_MTVAL  = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        V_DROP  = 2'd0,
        V_OFFER = 2'd1,
        V_ACK   = 2'd2
    } t_verdict;

    localparam logic [1:0] REG_PREFIX     = 2'd0;
    localparam logic [1:0] REG_SERVER     = 2'd1;
    localparam logic [1:0] REG_FIRST_HOST = 2'd2;

    localparam logic [23:0] PREFIX_RESET     = 24'h0A_0000;
    localparam logic [31:0] SERVER_RESET     = 32'h0A00_0001;
    localparam logic [7:0]  FIRST_HOST_RESET = 8'd10;

    localparam logic [7:0] OP_REQUEST   = 8'd1;
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_END      = 8'd255;
    localparam logic [7:0] MT_DISCOVER  = 8'd1;
    localparam logic [7:0] MT_REQUEST   = 8'd3;

    localparam logic [1:0] COOKIE_LAST = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] skip;
        t_verdict   decision;
    } t_walk;

    typedef struct packed {
        logic     has_result;
        t_verdict verdict;
    } t_parse_res;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] client_address;
        logic [31:0] reply_server;
    } t_result;

    function automatic logic [7:0] cookie_at(logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'd99;
            2'd1:    b = 8'd130;
            2'd2:    b = 8'd83;
            default: b = 8'd99;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: sv/dmtr_in_if.sv
// Byte input channel of the DHCP message type responder.
`default_nettype none
interface dmtr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;
    logic       last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/dmtr_out_if.sv
// Verdict output channel of the DHCP message type responder.
`default_nettype none
interface dmtr_out_if;
    import dmtr_pkg::*;

    logic        valid;
    logic        ready;
    t_verdict    verdict;
    logic [31:0] client_address;
    logic [31:0] reply_server;

    modport source (output valid, output verdict, output client_address,
                    output reply_server, input ready);
    modport sink   (input valid, input verdict, input client_address,
                    input reply_server, output ready);
endinterface
`default_nettype wire

FILE: sv/dmtr_parser.sv
// Option walker: cookie skip, TLV walk and message type decision per byte.
`default_nettype none
module dmtr_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire dmtr_pkg::t_item     i_item,
    output dmtr_pkg::t_parse_res     o_res
);
    import dmtr_pkg::*;

    t_phase     r_phase;
    logic [7:0] r_skip;
    t_verdict   r_decision;
    logic [1:0] r_pos;

    t_walk      w;
    logic [1:0] n_pos;
    t_walk      n_w;

    function automatic t_walk walk(t_walk s, logic [7:0] b);
        t_walk      n;
        logic [7:0] dec;
        n   = s;
        dec = s.skip - 8'd1;
        case (s.phase)
            PH_TYPE: begin
                if (b == OPT_END) begin
                    n.decision = V_DROP;
                    n.phase    = PH_DONE;
                end else if (b == OPT_MSG_TYPE) begin
                    n.phase = PH_MTLEN;
                end else if (b == OPT_PAD) begin
                    n.phase = PH_TYPE;
                end else begin
                    n.phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n.skip  = b;
                n.phase = (b == 8'd0) ? PH_TYPE : PH_SKIP;
            end
            PH_SKIP: begin
                n.skip = dec;
                if (dec == 8'd0) begin
                    n.phase = PH_TYPE;
                end
            end
            PH_MTLEN: begin
                n.phase = PH_MTVAL;
            end
            PH_MTVAL: begin
                if (b == MT_DISCOVER) begin
                    n.decision = V_OFFER;
                end else if (b == MT_REQUEST) begin
                    n.decision = V_ACK;
                end else begin
                    n.decision = V_DROP;
                end
                n.phase = PH_DONE;
            end
            default: ;
        endcase
        return n;
    endfunction

    always_comb begin
        w.phase    = r_phase;
        w.skip     = r_skip;
        w.decision = r_decision;
        n_w        = w;
        n_pos      = r_pos;
        o_res.has_result = i_item.last;
        if (!i_item.kind) begin
            n_w.phase    = (i_item.data == OP_REQUEST) ? PH_COOKIE : PH_DONE;
            n_w.skip     = 8'd0;
            n_w.decision = V_DROP;
            n_pos        = 2'd0;
        end else if (r_phase == PH_IDLE) begin
            o_res.has_result = 1'b0;
        end else if (r_phase == PH_COOKIE) begin
            if (i_item.data == cookie_at(r_pos)) begin
                if (r_pos == COOKIE_LAST) begin
                    n_w.phase = PH_TYPE;
                    n_pos     = 2'd0;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end else begin
                // replay the matched cookie prefix as options, then this byte
                n_w.phase = PH_TYPE;
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_pos) begin
                        n_w = walk(n_w, cookie_at(2'(i)));
                    end
                end
                n_w   = walk(n_w, i_item.data);
                n_pos = 2'd0;
            end
        end else begin
            n_w = walk(w, i_item.data);
        end
        o_res.verdict = (n_w.phase == PH_DONE) ? n_w.decision : V_DROP;
        if (o_res.has_result) begin
            n_w.phase    = PH_IDLE;
            n_w.skip     = 8'd0;
            n_w.decision = V_DROP;
            n_pos        = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_skip     <= 8'd0;
            r_decision <= V_DROP;
            r_pos      <= 2'd0;
        end else if (i_step) begin
            r_phase    <= n_w.phase;
            r_skip     <= n_w.skip;
            r_decision <= n_w.decision;
            r_pos      <= n_pos;
        end
    end

endmodule
`default_nettype wire

FILE: sv/dmtr_out_reg.sv
// Result register driving the verdict output channel.
`default_nettype none
module dmtr_out_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire dmtr_pkg::t_result i_data,
    output logic                o_free,
    dmtr_out_if.source          o_out
);
    import dmtr_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.verdict        = r_data.verdict;
    assign o_out.client_address = r_data.client_address;
    assign o_out.reply_server   = r_data.reply_server;

endmodule
`default_nettype wire

FILE: sv/dhcp_message_type_responder.sv
// Top level of the DHCP message type responder.
// Usage:
//   i_in carries one message byte per item: kind 0 is the header op byte that
//   opens a message, kind 1 an option-area byte; last marks the final byte.
//   o_out carries one verdict item per finished message (drop, offer, ack)
//   with the assigned client address and the server address (both zero on a drop).
//   i_cfg_we/i_cfg_index/i_cfg_data write network_prefix (0), server_address
//   (1) and first_host (2); writing first_host reloads the host counter.
// Timing:
//   One byte per clock is accepted unless a byte that ends a message waits on
//   a stalled o_out. A byte lands in the input register when accepted; the
//   parser and the result register then act on it, so a verdict reaches o_out
//   through both registers. The per-byte cost is the option walk of up to four
//   bytes when a partial cookie is replayed.
// Reset and stalls:
//   Reset empties both registers, returns the parser to idle and restores the
//   register defaults and the host counter to 10. While o_out is stalled with
//   a verdict pending, bytes that make no verdict still flow; a byte that ends
//   a message waits in the input register and i_in.ready falls.
`default_nettype none
module dhcp_message_type_responder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    dmtr_in_if.sink          i_in,
    dmtr_out_if.source       o_out
);
    import dmtr_pkg::*;

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic [23:0] r_prefix;
    logic [31:0] r_server;
    logic [7:0]  r_next_host;

    t_parse_res  w_res;
    t_result     w_result;
    logic        w_out_free;
    logic        w_s1_adv;
    logic        w_load;
    logic        w_ack_load;
    logic        w_addr;

    dmtr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_s1_adv),
        .i_item  (r_s1_item),
        .o_res   (w_res)
    );

    assign w_s1_adv   = r_s1_valid && (!w_res.has_result || w_out_free);
    assign w_load     = w_s1_adv && w_res.has_result;
    assign w_ack_load = w_load && (w_res.verdict == V_ACK);
    assign i_in.ready = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item.kind <= i_in.kind;
            r_s1_item.data <= i_in.data;
            r_s1_item.last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix    <= PREFIX_RESET;
            r_server    <= SERVER_RESET;
            r_next_host <= FIRST_HOST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PREFIX:     r_prefix    <= i_cfg_data[23:0];
                REG_SERVER:     r_server    <= i_cfg_data;
                REG_FIRST_HOST: r_next_host <= i_cfg_data[7:0];
                default: ;
            endcase
        end else if (w_ack_load) begin
            r_next_host <= r_next_host + 8'd1;
        end
    end

    assign w_addr = (w_res.verdict == V_OFFER) || (w_res.verdict == V_ACK);

    always_comb begin
        w_result.verdict        = w_res.verdict;
        w_result.client_address = w_addr ? {r_prefix, r_next_host} : 32'd0;
        w_result.reply_server   = w_addr ? r_server : 32'd0;
    end

    dmtr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_result),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

    a_host_moves_on_ack_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we) && !$past(w_ack_load)) |-> $stable(r_next_host))
        else $error("host counter changed without an ack or a write");

    a_drop_has_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.verdict == V_DROP)
            |-> (o_out.client_address == 32'd0 && o_out.reply_server == 32'd0))
        else $error("drop verdict carries an address");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("stalled item lost from the input register");

    a_ack_counts_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ack_load && !i_cfg_we) |=> (r_next_host == $past(r_next_host) + 8'd1))
        else $error("ack did not advance the host counter");

endmodule
`default_nettype wire
